[rtl/core/bcu_pkg.sv]
// ----------------------------------------------------------------------------
// bcu_pkg
// Shared types and codes for the bounding box center and unitize block.
// ----------------------------------------------------------------------------
package bcu_pkg;

    // input operation codes, carried in the slave tuser
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ACCUM = 2'd1;
    localparam logic [1:0] OP_XFORM = 2'd2;

    // configuration register indexes
    localparam int unsigned   CFG_IDX_W    = 8;
    localparam logic [7:0]    REG_RECENTER = 8'd0;
    localparam logic [7:0]    REG_RESIZE   = 8'd1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROUND
    } state_t;

    // per-item control broadcast to the lanes and the merge stage
    typedef struct packed {
        logic clear;
        logic accum;
        logic load;
        logic step;
    } lane_ctrl_t;

endpackage

[rtl/core/bbox_center_unitize.sv]
// ----------------------------------------------------------------------------
// bbox_center_unitize
// Bounding box recenter and unit-cube resize of signed fixed-point vertices,
// three axis lanes working side by side with a merge stage for the divisor.
// ----------------------------------------------------------------------------
//
//  channel  | direction | transfer carries
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tuser: op; tdata: coord_x, coord_y, coord_z
//  m_axis   | out       | tuser: degenerate; tdata: norm_x, norm_y, norm_z
//  cfg      | in        | cfg_index: register index; cfg_data: bit 0 value
//
//  Clear and accumulate produce no output transfer.
//  An accepted transform runs the divide state, one bit per cycle in the
//  restoring divider of each lane, then the round state, then output valid.
//  One item is in work at a time; the next is taken while a result waits
//  in the output register. A held output stalls only the round step.
//  Reset clears the bounds, the seen flag and both configuration bits.
// ----------------------------------------------------------------------------
module bbox_center_unitize
    import bcu_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // coord_x, coord_y, coord_z from bit 0 up, zero padded to bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  logic [1:0]                 s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // norm_x, norm_y, norm_z from bit 0 up, zero padded to bytes
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic                       m_axis_tuser,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic                       cfg_data
);

    localparam int CW      = COORD_WIDTH;
    localparam int FB      = FRAC_BITS;
    localparam int TDATA_W = ((3*CW+7)/8)*8;
    localparam int DEN_W   = (CW > FB + 2) ? CW : FB + 2;
    localparam int NB      = CW + 2 + FB;
    localparam int CNT_W   = $clog2(NB);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                recenter_reg;
    logic                resize_reg;
    logic                m_valid_reg;
    logic [TDATA_W-1:0]  m_data_reg;
    logic                m_degen_reg;

    lane_ctrl_t          ctrl;
    logic                out_free;
    logic                out_load;
    logic                any_seen;
    logic                degen;
    logic [DEN_W-1:0]    den;
    logic [DEN_W-1:0]    ext [3];
    logic [CW-1:0]       res [3];

    assign out_free = !m_valid_reg || m_axis_tready;

    // configuration writes, always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recenter_reg <= 1'b0;
            resize_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RECENTER: recenter_reg <= cfg_data;
                REG_RESIZE:   resize_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tuser == OP_XFORM)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NB - 1))
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        ctrl          = '0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                ctrl.clear    = s_axis_tvalid && s_axis_tuser == OP_CLEAR;
                ctrl.accum    = s_axis_tvalid && s_axis_tuser == OP_ACCUM;
                ctrl.load     = s_axis_tvalid && s_axis_tuser == OP_XFORM;
            end
            ST_DIV:   ctrl.step = 1'b1;
            ST_ROUND: out_load  = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // axis lanes
    for (genvar a = 0; a < 3; a++)
    begin : g_lane
        bcu_lane #(
            .CW    (CW),
            .FB    (FB),
            .DEN_W (DEN_W)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .coord    (s_axis_tdata[a*CW +: CW]),
            .recenter (recenter_reg && any_seen),
            .den      (den),
            .ext      (ext[a]),
            .result   (res[a])
        );
    end

    // divisor and degenerate flag from the lane extents
    bcu_merge #(
        .FB    (FB),
        .DEN_W (DEN_W)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .resize   (resize_reg),
        .ext_x    (ext[0]),
        .ext_y    (ext[1]),
        .ext_z    (ext[2]),
        .den      (den),
        .degen    (degen),
        .any_seen (any_seen)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg  <= TDATA_W'({res[2], res[1], res[0]});
            m_degen_reg <= degen;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_degen_reg;

endmodule

[rtl/core/bcu_lane.sv]
// ----------------------------------------------------------------------------
// bcu_lane
// One axis: running min/max bounds, numerator build and a bit-serial
// restoring divider with round-half-away and saturation.
// ----------------------------------------------------------------------------
module bcu_lane
    import bcu_pkg::*;
#(
    parameter int CW    = 32,
    parameter int FB    = 16,
    parameter int DEN_W = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_ctrl_t       ctrl,
    input  logic [CW-1:0]    coord,
    input  logic             recenter,
    input  logic [DEN_W-1:0] den,
    output logic [DEN_W-1:0] ext,
    output logic [CW-1:0]    result
);

    localparam int NW = CW + 2;       // numerator width
    localparam int NB = NW + FB;      // dividend bits fed to the divider
    localparam int QW = CW + 1;       // kept quotient bits

    localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic             neg_reg, neg_next;
    logic [NB-1:0]    sh_reg, sh_next;
    logic [DEN_W-1:0] r_reg, r_next;
    logic [QW-1:0]    q_reg, q_next;
    logic             ovf_reg, ovf_next;

    logic [CW:0]      diff;
    logic [NW-1:0]    num2v;
    logic [NW-1:0]    bsum;
    logic [NW-1:0]    num;
    logic [NW-1:0]    mag;
    logic [DEN_W:0]   r_shift;
    logic [DEN_W:0]   r_sub;
    logic             ge;
    logic             round_up;
    logic [QW:0]      qr;
    logic             big;

    // extent of this axis, valid once a vertex has been seen
    assign diff = {hi_reg[CW-1], hi_reg} - {lo_reg[CW-1], lo_reg};
    assign ext  = DEN_W'(diff[CW-1:0]);

    // numerator 2*v - (lo + hi) when recentering, else 2*v
    assign num2v = {coord[CW-1], coord, 1'b0};
    assign bsum  = {{2{lo_reg[CW-1]}}, lo_reg} + {{2{hi_reg[CW-1]}}, hi_reg};
    assign num   = recenter ? (num2v - bsum) : num2v;
    assign mag   = num[NW-1] ? (~num + NW'(1)) : num;

    // one restoring step
    assign r_shift = {r_reg, sh_reg[NB-1]};
    assign r_sub   = r_shift - {1'b0, den};
    assign ge      = (r_shift >= {1'b0, den});

    // rounding and saturation of the finished quotient
    assign round_up = ({r_reg, 1'b0} >= {1'b0, den});
    assign qr       = {1'b0, q_reg} + (QW+1)'(round_up);
    assign big      = ovf_reg | (|qr[QW:CW-1]);

    always_comb
    begin
        if (neg_reg)
            result = big ? MINV : (~qr[CW-1:0] + CW'(1));
        else
            result = big ? MAXV : qr[CW-1:0];
    end

    // bounds next value
    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.clear)
        begin
            lo_next = MAXV;
            hi_next = MINV;
        end
        else if (ctrl.accum)
        begin
            if ($signed(coord) < $signed(lo_reg))
                lo_next = coord;
            if ($signed(coord) > $signed(hi_reg))
                hi_next = coord;
        end
    end

    // divider next value
    always_comb
    begin
        neg_next = neg_reg;
        sh_next  = sh_reg;
        r_next   = r_reg;
        q_next   = q_reg;
        ovf_next = ovf_reg;
        if (ctrl.load)
        begin
            neg_next = num[NW-1];
            sh_next  = {mag, {FB{1'b0}}};
            r_next   = '0;
            q_next   = '0;
            ovf_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            sh_next  = {sh_reg[NB-2:0], 1'b0};
            r_next   = ge ? r_sub[DEN_W-1:0] : r_shift[DEN_W-1:0];
            q_next   = {q_reg[QW-2:0], ge};
            ovf_next = ovf_reg | q_reg[QW-1];
        end
    end

    // bounds registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= MAXV;
            hi_reg <= MINV;
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    // divider datapath registers
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        sh_reg  <= sh_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

endmodule

[rtl/core/bcu_merge.sv]
// ----------------------------------------------------------------------------
// bcu_merge
// Combines the lane extents into the shared divisor and degenerate flag,
// and tracks whether any vertex has been folded in.
// ----------------------------------------------------------------------------
module bcu_merge
    import bcu_pkg::*;
#(
    parameter int FB    = 16,
    parameter int DEN_W = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_ctrl_t       ctrl,
    input  logic             resize,
    input  logic [DEN_W-1:0] ext_x,
    input  logic [DEN_W-1:0] ext_y,
    input  logic [DEN_W-1:0] ext_z,
    output logic [DEN_W-1:0] den,
    output logic             degen,
    output logic             any_seen
);

    localparam logic [DEN_W-1:0] DEN_ONE = DEN_W'(1) << (FB + 1);

    logic [DEN_W-1:0] den_reg, den_next;
    logic             degen_reg, degen_next;
    logic             seen_reg, seen_next;
    logic [DEN_W-1:0] mx_xy;
    logic [DEN_W-1:0] mx;

    // largest extent over the three axes
    assign mx_xy = (ext_y > ext_x) ? ext_y : ext_x;
    assign mx    = (ext_z > mx_xy) ? ext_z : mx_xy;

    always_comb
    begin
        den_next   = den_reg;
        degen_next = degen_reg;
        seen_next  = seen_reg;
        if (ctrl.clear)
            seen_next = 1'b0;
        else if (ctrl.accum)
            seen_next = 1'b1;
        else if (ctrl.load)
        begin
            den_next   = DEN_ONE;
            degen_next = 1'b0;
            if (resize && seen_reg)
            begin
                if (mx == '0)
                    degen_next = 1'b1;
                else
                    den_next = mx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else
            seen_reg <= seen_next;
    end

    always_ff @(posedge clk)
    begin
        den_reg   <= den_next;
        degen_reg <= degen_next;
    end

    assign den      = den_reg;
    assign degen    = degen_reg;
    assign any_seen = seen_reg;

endmodule
